>>> src/msw_pkg.sv
// Shared types, constants and helpers for the sliding-window-minimum core.
// No dependencies; imported by every design module of the block.
`timescale 1ns / 1ps

package msw_pkg;

  localparam int MAX_WINDOW  = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int WIN_BITS    = 7;
  localparam int COUNT_BITS  = 16;
  localparam int TREE_FAN    = 4;
  localparam int TREE_L1     = MAX_WINDOW / TREE_FAN;
  localparam int TREE_L2     = TREE_L1 / TREE_FAN;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [WIN_BITS-1:0]    win_t;
  typedef logic [COUNT_BITS-1:0]  count_t;

  localparam win_t    WIN_RESET    = win_t'(4);
  localparam win_t    WIN_MAX      = win_t'(MAX_WINDOW);
  localparam count_t  COUNT_MAX    = '1;
  localparam sample_t SAMPLE_EMPTY = '1;

  // Sideband carried alongside a beat through the min pipeline.
  typedef struct packed {
    logic last;  // beat closes the line
    logic upd;   // full window seen: front may raise the best level
  } tag_t;

  function automatic sample_t min4(input sample_t a, input sample_t b,
                                   input sample_t c, input sample_t d);
    sample_t ab;
    sample_t cd;
    ab = (a < b) ? a : b;
    cd = (c < d) ? c : d;
    return (ab < cd) ? ab : cd;
  endfunction

endpackage

>>> src/msw_cell.sv
// One cell of the candidate chain: holds one sample and its live bit.
// Depends on msw_pkg.
`timescale 1ns / 1ps

module msw_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             clr,
  input  logic             keep,
  input  msw_pkg::sample_t sample,
  input  msw_pkg::sample_t in_value,
  input  logic             in_live,
  output msw_pkg::sample_t value,
  output logic             live,
  output logic             pass
);
  import msw_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      live <= 1'b0;
    end else if (en) begin
      live <= in_live;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      value <= in_value;
    end
  end

  // Survives the move one age step on: still inside the window and
  // strictly below the incoming sample (otherwise popped from the back).
  assign pass = live & ~clr & keep & (value < sample);

endmodule

>>> src/msw_chain.sv
// Row of msw_cell; cell k holds the entry of age k, shifting once per beat.
// Depends on msw_pkg and msw_cell.
`timescale 1ns / 1ps

module msw_chain (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             clr,
  input  msw_pkg::win_t    w_eff,
  input  msw_pkg::sample_t sample,
  output msw_pkg::sample_t values [msw_pkg::MAX_WINDOW],
  output logic             lives  [msw_pkg::MAX_WINDOW]
);
  import msw_pkg::*;

  logic pass [MAX_WINDOW-1];

  genvar k;
  generate
    for (k = 0; k < MAX_WINDOW; k++) begin : g_cell
      logic    keep;
      sample_t in_value;
      logic    in_live;

      // entry moving out of cell k reaches age k+1
      assign keep = (win_t'(k + 1) < w_eff);

      if (k == 0) begin : g_head
        assign in_value = sample;
        assign in_live  = 1'b1;
      end else begin : g_body
        assign in_value = values[k-1];
        assign in_live  = pass[k-1];
      end

      if (k < MAX_WINDOW - 1) begin : g_link
        msw_cell u_cell (
          .clk      (clk),
          .rst      (rst),
          .en       (en),
          .clr      (clr),
          .keep     (keep),
          .sample   (sample),
          .in_value (in_value),
          .in_live  (in_live),
          .value    (values[k]),
          .live     (lives[k]),
          .pass     (pass[k])
        );
      end else begin : g_tail
        // oldest cell: its entry always ages out of any window
        msw_cell u_cell (
          .clk      (clk),
          .rst      (rst),
          .en       (en),
          .clr      (clr),
          .keep     (keep),
          .sample   (sample),
          .in_value (in_value),
          .in_live  (in_live),
          .value    (values[k]),
          .live     (lives[k]),
          .pass     ()
        );
      end
    end
  endgenerate

endmodule

>>> src/msw_min_tree.sv
// Three-stage registered minimum over the live cells: gives the queue front.
// Depends on msw_pkg.
`timescale 1ns / 1ps

module msw_min_tree (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  msw_pkg::tag_t    in_tag,
  input  msw_pkg::sample_t values [msw_pkg::MAX_WINDOW],
  input  logic             lives  [msw_pkg::MAX_WINDOW],
  output logic             out_valid,
  output msw_pkg::tag_t    out_tag,
  output msw_pkg::sample_t front,
  output logic             last_busy
);
  import msw_pkg::*;

  sample_t masked [MAX_WINDOW];
  sample_t l1     [TREE_L1];
  sample_t l2     [TREE_L2];
  logic    v1, v2;
  tag_t    t1, t2;

  always_comb begin
    for (int i = 0; i < MAX_WINDOW; i++) begin
      masked[i] = lives[i] ? values[i] : SAMPLE_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < TREE_L1; g++) begin
      l1[g] <= min4(masked[4*g], masked[4*g+1], masked[4*g+2], masked[4*g+3]);
    end
    for (int g = 0; g < TREE_L2; g++) begin
      l2[g] <= min4(l1[4*g], l1[4*g+1], l1[4*g+2], l1[4*g+3]);
    end
    front <= min4(l2[0], l2[1], l2[2], l2[3]);
    t1      <= in_tag;
    t2      <= t1;
    out_tag <= t2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  assign last_busy = (v1 & t1.last) | (v2 & t2.last) | (out_valid & out_tag.last);

endmodule

>>> src/max_of_sliding_window_minimum_core.sv
// Largest sliding-window minimum of a line; one result beat per line.
// Throughput: one sample beat per cycle within a line while no result beat is
// stalled; after a line end the input pauses until that line end has left the min tree.
// The result beat is registered after the end_of_line beat is taken and passes
// the chain register, the 3-stage min tree and the result register.
// Reset (rst, synchronous): empties the queue, window_length back to 4.
`timescale 1ns / 1ps

module max_of_sliding_window_minimum_core (
  input  logic                    clk,
  input  logic                    rst,
  // config: window_length, 0..64 (above 64 acts as 64)
  input  logic                    cfg_wr_en,
  input  logic [6:0]              cfg_wr_data,
  // sample stream
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [15:0]             s_tdata,   // [15:0] sample
  input  logic                    s_tlast,   // end_of_line
  // result stream
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [15:0]             m_tdata    // [15:0] line_level
);
  import msw_pkg::*;

  // ---------------------------------------------------------------------
  // Control and line state
  // ---------------------------------------------------------------------
  win_t    window_length;
  win_t    w_eff;
  count_t  count;
  count_t  count_next;
  logic    fresh;        // next beat starts a new line: chain contents stale
  logic    accept;
  logic    upd;

  logic    v0;           // chain holds the snapshot of the beat just taken
  tag_t    tag0;

  sample_t values [MAX_WINDOW];
  logic    lives  [MAX_WINDOW];

  logic    tv;
  tag_t    tt;
  sample_t front;
  logic    tree_last_busy;

  sample_t best;
  sample_t best_new;

  assign accept = s_tvalid & s_tready;
  assign w_eff  = (window_length > WIN_MAX) ? WIN_MAX : window_length;

  // saturating per-line beat count, already counting the current beat
  assign count_next = (count == COUNT_MAX) ? count : count + count_t'(1);
  assign upd        = (w_eff != '0) && (count_t'(w_eff) <= count_next);

  // One line end in flight at a time; the result register must be free.
  assign s_tready = ~(v0 & tag0.last) & ~tree_last_busy & ~(m_tvalid & ~m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WIN_RESET;
    end else if (cfg_wr_en) begin
      window_length <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      fresh <= 1'b1;
      v0    <= 1'b0;
    end else begin
      v0 <= accept;
      if (accept) begin
        count <= s_tlast ? '0 : count_next;
        fresh <= s_tlast;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tag0 <= '{last: s_tlast, upd: upd};
    end
  end

  // ---------------------------------------------------------------------
  // Candidate queue: cell k holds the sample of age k. On each beat every
  // live entry moves one cell on if it stays inside the window and is below
  // the new sample; the new sample always enters cell 0. Live values then
  // rise from old to new, so the front is the minimum of the live cells.
  // ---------------------------------------------------------------------
  msw_chain u_chain (
    .clk    (clk),
    .rst    (rst),
    .en     (accept),
    .clr    (fresh),
    .w_eff  (w_eff),
    .sample (s_tdata),
    .values (values),
    .lives  (lives)
  );

  msw_min_tree u_tree (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v0),
    .in_tag    (tag0),
    .values    (values),
    .lives     (lives),
    .out_valid (tv),
    .out_tag   (tt),
    .front     (front),
    .last_busy (tree_last_busy)
  );

  // ---------------------------------------------------------------------
  // Best level and result register
  // ---------------------------------------------------------------------
  assign best_new = (tt.upd && (front > best)) ? front : best;

  always_ff @(posedge clk) begin
    if (rst) begin
      best     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (tv) begin
        if (tt.last) begin
          m_tvalid <= 1'b1;
          best     <= '0;
        end else begin
          best <= best_new;
        end
      end
    end
  end

  // window zero or short line: no full window at the line end gives zero
  always_ff @(posedge clk) begin
    if (tv && tt.last) begin
      m_tdata <= tt.upd ? best_new : '0;
    end
  end

endmodule

>>> src/msw_checker.sv
// Port-level checks for max_of_sliding_window_minimum_core, bound to it.
// Depends on the top level's port list only.
`timescale 1ns / 1ps

module msw_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_wr_en,
  input logic [6:0]  cfg_wr_data,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [15:0] s_tdata,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // a line end closes the input right after it is taken
  a_last_blocks: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input open right after a line end");

  // no input while a result is stalled
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input open while result stalled");

  // result goes valid only after its line end has passed the chain, the tree and the result register
  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 5))
    else $error("result beat without a line end at the pipeline depth before");

endmodule

bind max_of_sliding_window_minimum_core msw_checker u_msw_checker (.*);
